// File: hw/rtl/assert_macros.svh
// Assertion macros for the altitude filter RTL.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AKF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define AKF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AKF_ASSERT(label, prop, msg)
`define AKF_ASSERT_RST(label, prop, msg)
`endif
`endif

// File: hw/rtl/akf_pkg.sv
// Package for the altitude filter: word constants, saturation helpers, command types.
// Depends on nothing.
`default_nettype none
package akf_pkg;
  localparam int W = 32;
  localparam int F = 16;
  localparam int CW = 31;
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE = W'(64'sd1 <<< F);

  localparam logic [1:0] REG_DT = 2'd0;
  localparam logic [1:0] REG_RN = 2'd1;
  localparam logic [1:0] REG_QP = 2'd2;
  localparam logic [1:0] REG_QV = 2'd3;

  // datapath operations
  localparam logic [2:0] OP_MUL = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_HALF = 3'd4;
  localparam logic [2:0] OP_MOV = 3'd5;

  // register file slots
  localparam int NREG = 32;
  typedef logic [4:0] rsel_t;

  typedef struct packed {
    logic start;
    logic [2:0] op;
    rsel_t a;
    rsel_t b;
    rsel_t d;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } stat_t;

  function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] x);
    if (x > (W+2)'(WMAX)) return WMAX;
    if (x < (W+2)'(WMIN)) return WMIN;
    return x[W-1:0];
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/akf_if.sv
// Valid/ready channel interfaces for the altitude filter.
// Depends on akf_pkg.
`default_nettype none
interface akf_in_if;
  logic valid;
  logic ready;
  logic signed [akf_pkg::W-1:0] accel;
  logic signed [akf_pkg::W-1:0] altitude_meas;
  modport source (output valid, accel, altitude_meas, input ready);
  modport sink (input valid, accel, altitude_meas, output ready);
endinterface

interface akf_out_if;
  logic valid;
  logic ready;
  logic signed [akf_pkg::W-1:0] position_est;
  logic signed [akf_pkg::W-1:0] velocity_est;
  modport source (output valid, position_est, velocity_est, input ready);
  modport sink (input valid, position_est, velocity_est, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/akf_datapath.sv
// Datapath: register file, one multiplier, one adder, serial divider, output register.
// Depends on akf_pkg; driven by akf_ctrl.
`default_nettype none
module akf_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire akf_pkg::cmd_t cmd,
  output akf_pkg::stat_t stat,
  input  wire logic load,
  input  wire logic capture,
  input  wire logic signed [akf_pkg::W-1:0] accel,
  input  wire logic signed [akf_pkg::W-1:0] altitude_meas,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [akf_pkg::CW-1:0] cfg_data,
  output logic signed [akf_pkg::W-1:0] position,
  output logic signed [akf_pkg::W-1:0] velocity
);
  localparam int W = akf_pkg::W;
  localparam int F = akf_pkg::F;
  localparam int NB = W + F;

  logic signed [W-1:0] rf [akf_pkg::NREG];
  logic signed [W-1:0] a, b, res;
  logic [W:0] ma, mb;
  logic neg;
  logic [2*W+1:0] prod;
  logic [2*W+1:0] prnd;
  logic [W+1:0] lim;
  logic signed [W+1:0] sum;
  // divider
  logic [5:0] cnt;
  logic dbusy;
  logic dneg;
  akf_pkg::rsel_t ddst;
  logic [NB-1:0] num;
  logic [NB-1:0] quo;
  logic [W-1:0] den;
  logic [W-1:0] rem;
  logic [W:0] rsh;
  logic [W:0] rdiff;
  logic dge;
  logic [NB-1:0] dlim;
  logic signed [W-1:0] dres;

  assign a = rf[cmd.a];
  assign b = rf[cmd.b];
  assign ma = a[W-1] ? (W+1)'(-$signed({a[W-1], a})) : {1'b0, a};
  assign mb = b[W-1] ? (W+1)'(-$signed({b[W-1], b})) : {1'b0, b};
  assign neg = a[W-1] ^ b[W-1];
  assign prod = ma * mb;
  assign prnd = (prod + ((2*W+2)'(1) << (F-1))) >> F;
  assign lim = (W+2)'(akf_pkg::WMAX) + (W+2)'(neg);

  always_comb begin
    sum = '0;
    res = '0;
    case (cmd.op)
      akf_pkg::OP_MUL: begin
        if (prnd > (2*W+2)'(lim)) res = neg ? akf_pkg::WMIN : akf_pkg::WMAX;
        else res = neg ? W'(-$signed({1'b0, prnd[W:0]})) : prnd[W-1:0];
      end
      akf_pkg::OP_ADD: begin
        sum = (W+2)'(a) + (W+2)'(b);
        res = akf_pkg::sat(sum);
      end
      akf_pkg::OP_SUB: begin
        sum = (W+2)'(a) - (W+2)'(b);
        res = akf_pkg::sat(sum);
      end
      akf_pkg::OP_HALF: res = a / 2;
      akf_pkg::OP_MOV: res = a;
      default: res = a;
    endcase
  end

  assign rsh = {rem, num[NB-1]};
  assign rdiff = rsh - {1'b0, den};
  assign dge = rsh >= {1'b0, den};
  assign dlim = NB'(akf_pkg::WMAX) + NB'(dneg);
  assign dres = (quo > dlim) ? (dneg ? akf_pkg::WMIN : akf_pkg::WMAX)
              : (dneg ? W'(-$signed({1'b0, quo[W-1:0]})) : quo[W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      cnt <= '0;
      position <= '0;
      velocity <= '0;
      rf[0] <= '0; rf[1] <= '0; rf[2] <= akf_pkg::ONE; rf[3] <= '0;
      rf[4] <= '0; rf[5] <= akf_pkg::ONE;
      rf[6] <= 32'sd65536; rf[7] <= 32'sd204; rf[8] <= 32'sd66; rf[9] <= 32'sd655;
      rf[31] <= akf_pkg::ONE;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          akf_pkg::REG_DT: rf[6] <= {1'b0, cfg_data};
          akf_pkg::REG_RN: rf[7] <= {1'b0, cfg_data};
          akf_pkg::REG_QP: rf[8] <= {1'b0, cfg_data};
          akf_pkg::REG_QV: rf[9] <= {1'b0, cfg_data};
          default: ;
        endcase
      end
      if (load) begin
        rf[10] <= accel;
        rf[11] <= altitude_meas;
      end
      if (capture) begin
        position <= rf[0];
        velocity <= rf[1];
      end
      if (cmd.start) begin
        if (cmd.op == akf_pkg::OP_DIV) begin
          if (b == '0) rf[cmd.d] <= '0;
          else begin
            dbusy <= 1'b1;
            cnt <= '0;
            dneg <= neg;
            ddst <= cmd.d;
            num <= {ma[W-1:0], {F{1'b0}}};
            den <= mb[W-1:0];
            rem <= '0;
            quo <= '0;
          end
        end else rf[cmd.d] <= res;
      end
      if (dbusy) begin
        if (cnt == 6'(NB)) begin
          dbusy <= 1'b0;
          rf[ddst] <= dres;
        end else begin
          num <= {num[NB-2:0], 1'b0};
          quo <= {quo[NB-2:0], dge};
          if (dge) rem <= rdiff[W-1:0];
          else rem <= rsh[W-1:0];
          cnt <= cnt + 6'd1;
        end
      end
    end
  end

  assign stat.busy = dbusy;
endmodule
`default_nettype wire

// File: hw/rtl/akf_ctrl.sv
// Controller: sequences the filter microprogram over the datapath.
// Depends on akf_pkg; drives akf_datapath.
`default_nettype none
module akf_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic out_ready,
  input  wire akf_pkg::stat_t stat,
  output akf_pkg::cmd_t cmd,
  output logic idle,
  output logic capture,
  output logic ovalid
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [4:0] pc;
  logic [17:0] uop;
  logic issue;
  logic tail;

  // slots: 0 pos 1 vel 2 pp 3 pv 4 vp 5 vv 6 dt 7 rn 8 qp 9 qv 10 acc 11 z
  // temps 12.. ; 31 one
  always_comb begin
    case (pc)
      5'd0:  uop = {akf_pkg::OP_MUL, 5'd6, 5'd6, 5'd12};
      5'd1:  uop = {akf_pkg::OP_HALF, 5'd12, 5'd12, 5'd12};
      5'd2:  uop = {akf_pkg::OP_MUL, 5'd6, 5'd1, 5'd13};
      5'd3:  uop = {akf_pkg::OP_ADD, 5'd0, 5'd13, 5'd13};
      5'd4:  uop = {akf_pkg::OP_MUL, 5'd12, 5'd10, 5'd14};
      5'd5:  uop = {akf_pkg::OP_ADD, 5'd13, 5'd14, 5'd13};
      5'd6:  uop = {akf_pkg::OP_MUL, 5'd6, 5'd10, 5'd14};
      5'd7:  uop = {akf_pkg::OP_ADD, 5'd1, 5'd14, 5'd14};
      5'd8:  uop = {akf_pkg::OP_MUL, 5'd6, 5'd4, 5'd15};
      5'd9:  uop = {akf_pkg::OP_ADD, 5'd2, 5'd15, 5'd15};
      5'd10: uop = {akf_pkg::OP_MUL, 5'd6, 5'd5, 5'd16};
      5'd11: uop = {akf_pkg::OP_ADD, 5'd3, 5'd16, 5'd16};
      5'd12: uop = {akf_pkg::OP_MUL, 5'd16, 5'd6, 5'd17};
      5'd13: uop = {akf_pkg::OP_ADD, 5'd15, 5'd17, 5'd17};
      5'd14: uop = {akf_pkg::OP_ADD, 5'd17, 5'd8, 5'd17};
      5'd15: uop = {akf_pkg::OP_MUL, 5'd5, 5'd6, 5'd18};
      5'd16: uop = {akf_pkg::OP_ADD, 5'd4, 5'd18, 5'd18};
      5'd17: uop = {akf_pkg::OP_ADD, 5'd5, 5'd9, 5'd19};
      5'd18: uop = {akf_pkg::OP_ADD, 5'd17, 5'd7, 5'd20};
      5'd19: uop = {akf_pkg::OP_DIV, 5'd17, 5'd20, 5'd21};
      5'd20: uop = {akf_pkg::OP_DIV, 5'd18, 5'd20, 5'd22};
      5'd21: uop = {akf_pkg::OP_SUB, 5'd11, 5'd13, 5'd23};
      5'd22: uop = {akf_pkg::OP_MUL, 5'd21, 5'd23, 5'd24};
      5'd23: uop = {akf_pkg::OP_ADD, 5'd13, 5'd24, 5'd0};
      5'd24: uop = {akf_pkg::OP_MUL, 5'd22, 5'd23, 5'd24};
      5'd25: uop = {akf_pkg::OP_ADD, 5'd14, 5'd24, 5'd1};
      5'd26: uop = {akf_pkg::OP_SUB, 5'd31, 5'd21, 5'd25};
      5'd27: uop = {akf_pkg::OP_MUL, 5'd25, 5'd17, 5'd2};
      5'd28: uop = {akf_pkg::OP_MUL, 5'd25, 5'd16, 5'd3};
      5'd29: uop = {akf_pkg::OP_MUL, 5'd22, 5'd17, 5'd26};
      5'd30: uop = {akf_pkg::OP_SUB, 5'd18, 5'd26, 5'd4};
      5'd31: uop = {akf_pkg::OP_MUL, 5'd22, 5'd16, 5'd27};
      default: uop = '0;
    endcase
  end

  // final step handled as an extra tail op
  assign issue = state == S_RUN && !stat.busy;
  always_comb begin
    cmd.start = issue;
    if (tail) begin
      cmd.op = akf_pkg::OP_SUB; cmd.a = 5'd19; cmd.b = 5'd27; cmd.d = 5'd5;
    end else begin
      cmd.op = uop[17:15]; cmd.a = uop[14:10]; cmd.b = uop[9:5]; cmd.d = uop[4:0];
    end
  end

  assign capture = state == S_DONE && (!ovalid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc <= '0;
      tail <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      if (capture) ovalid <= 1'b1;
      else if (out_ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: if (in_fire) begin
          state <= S_RUN;
          pc <= '0;
          tail <= 1'b0;
        end
        S_RUN: if (issue) begin
          if (tail) state <= S_DONE;
          else if (pc == 5'd31) tail <= 1'b1;
          else pc <= pc + 5'd1;
        end
        S_DONE: if (capture) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = state == S_IDLE;
endmodule
`default_nettype wire

// File: hw/rtl/altitude_kalman_filter_unit.sv
// Top level of the two-state altitude Kalman filter.
// Depends on akf_pkg, akf_if, akf_ctrl, akf_datapath, assert_macros.svh.
//   channel   dir   payload
//   in        sink  accel, altitude_meas
//   out       src   position_est, velocity_est
//   cfg       in    cfg_we, cfg_idx, cfg_data
// Each item runs 33 steps on the datapath, two of them serial divisions, and then
// loads the output register; only then is the input free for the next item.
// A zero divisor skips both divisions. The result waits in the output register;
// while it waits, the next item runs and holds in its last step. Reset restores the
// state, the outputs and register slots 0-9 and 31 synchronously.
`default_nettype none
`include "assert_macros.svh"
module altitude_kalman_filter_unit (
  input  wire logic clk,
  input  wire logic rst,
  akf_in_if.sink in_ch,
  akf_out_if.source out_ch,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [akf_pkg::CW-1:0] cfg_data
);
  akf_pkg::cmd_t cmd;
  akf_pkg::stat_t stat;
  logic idle, capture, ovalid, in_fire;

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && idle;

  akf_ctrl u_ctrl (.clk, .rst, .in_fire, .out_ready(out_ch.ready), .stat, .cmd,
    .idle, .capture, .ovalid);
  akf_datapath u_dp (.clk, .rst, .cmd, .stat, .load(in_fire), .capture,
    .accel(in_ch.accel), .altitude_meas(in_ch.altitude_meas), .cfg_we, .cfg_idx,
    .cfg_data, .position(out_ch.position_est), .velocity(out_ch.velocity_est));
  assign out_ch.valid = ovalid;

  `AKF_ASSERT(a_div, stat.busy |-> !in_ch.ready, "accept during divide")
  `AKF_ASSERT_RST(a_rst, rst |=> in_ch.ready, "not idle after reset")
  `AKF_ASSERT(a_hold_v, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result dropped")
  `AKF_ASSERT(a_hold_p, out_ch.valid && !out_ch.ready |=> $stable(out_ch.position_est), "moved")
endmodule
`default_nettype wire
